// ----- rtl/jan_pkg.sv -----
package jan_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 15;
  localparam int MS_W     = 16;
  localparam int DIR_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd3;

  localparam logic [LEVEL_W-1:0] TRIGGER_RESET  = 15'd16384;
  localparam logic [LEVEL_W-1:0] RELAX_RESET    = 15'd11469;
  localparam logic [MS_W-1:0]    DELAY_RESET    = 16'd300;
  localparam logic [MS_W-1:0]    INTERVAL_RESET = 16'd150;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    LATCH_IDLE = 2'd0,
    LATCH_NEG  = 2'd1,
    LATCH_POS  = 2'd2
  } latch_t;

  typedef struct packed {
    latch_t             latch;
    logic               repeating;
    logic [TIME_W-1:0]  mark;
  } axis_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] trigger_level;
    logic [LEVEL_W-1:0] relax_level;
    logic [MS_W-1:0]    repeat_delay_ms;
    logic [MS_W-1:0]    repeat_interval_ms;
  } cfg_t;

endpackage

// ----- rtl/joystick_autorepeat_nav.sv -----
// Two-axis joystick to navigation events with hysteresis and auto-repeat. A
// beat with tuser 0 stores the x and y samples and produces nothing; a beat
// with tuser 1 carries the current millisecond time and produces up to two
// events, x axis first, with tlast on the final one. Input beats are
// registered and processed from that register once the output buffer has
// room, so a beat can be taken in every cycle while there is room; events
// leave at one per cycle while m_tready is high, from a two-entry buffer; an
// update that yields two events holds the input side until the second leaves.
module joystick_autorepeat_nav
  import jan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // x_sample[15:0], y_sample[31:16], now_ms[63:32]
  input  logic        s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // direction[1:0], zero fill[7:2]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic                in_valid;
  logic                in_kind;
  logic [SAMPLE_W-1:0] in_x;
  logic [SAMPLE_W-1:0] in_y;
  logic [TIME_W-1:0]   in_now;

  logic [SAMPLE_W-1:0] held_x;
  logic [SAMPLE_W-1:0] held_y;
  axis_state_t         x_st, y_st, x_st_next, y_st_next;
  logic                x_emit, y_emit, x_pos, y_pos;

  logic [1:0]          out_cnt;
  logic [DIR_W-1:0]    ev0_dir, ev1_dir;
  logic                ev0_last;

  logic                out_free;
  logic                proc;
  logic                pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level      <= TRIGGER_RESET;
      cfg.relax_level        <= RELAX_RESET;
      cfg.repeat_delay_ms    <= DELAY_RESET;
      cfg.repeat_interval_ms <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRIGGER:  cfg.trigger_level      <= cfg_data[LEVEL_W-1:0];
        CFG_RELAX:    cfg.relax_level        <= cfg_data[LEVEL_W-1:0];
        CFG_DELAY:    cfg.repeat_delay_ms    <= cfg_data[MS_W-1:0];
        CFG_INTERVAL: cfg.repeat_interval_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pop      = m_tvalid && m_tready;
  assign out_free = (out_cnt == 2'd0) || ((out_cnt == 2'd1) && m_tready);
  assign proc     = in_valid && out_free;
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_x    <= s_tdata[15:0];
      in_y    <= s_tdata[31:16];
      in_now  <= s_tdata[63:32];
    end
  end

  jan_axis u_axis_x (
    .cfg      (cfg),
    .cur      (x_st),
    .sample   ($signed(held_x)),
    .now_ms   (in_now),
    .nxt      (x_st_next),
    .emit     (x_emit),
    .positive (x_pos)
  );

  jan_axis u_axis_y (
    .cfg      (cfg),
    .cur      (y_st),
    .sample   ($signed(held_y)),
    .now_ms   (in_now),
    .nxt      (y_st_next),
    .emit     (y_emit),
    .positive (y_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
      x_st   <= '{latch: LATCH_IDLE, repeating: 1'b0, mark: '0};
      y_st   <= '{latch: LATCH_IDLE, repeating: 1'b0, mark: '0};
    end else if (proc) begin
      if (in_kind == KIND_SAMPLE) begin
        held_x <= in_x;
        held_y <= in_y;
      end else begin
        x_st <= x_st_next;
        y_st <= y_st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (proc) begin
      if (in_kind == KIND_UPDATE) begin
        out_cnt <= {1'b0, x_emit} + {1'b0, y_emit};
      end else begin
        out_cnt <= pop ? out_cnt - 2'd1 : out_cnt;
      end
    end else if (pop) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (in_kind == KIND_UPDATE)) begin
      ev1_dir <= {1'b1, y_pos};
      if (x_emit) begin
        ev0_dir  <= {1'b0, x_pos};
        ev0_last <= !y_emit;
      end else begin
        ev0_dir  <= {1'b1, y_pos};
        ev0_last <= 1'b1;
      end
    end else if (pop) begin
      ev0_dir  <= ev1_dir;
      ev0_last <= 1'b1;
    end
  end

  assign m_tvalid = (out_cnt != 2'd0);
  assign m_tdata  = {{(8-DIR_W){1'b0}}, ev0_dir};
  assign m_tlast  = ev0_last;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc |=> in_valid && $stable(in_kind) && $stable(in_now))
    else $error("input register changed while stalled");

  a_sample_keeps_state: assert property (@(posedge clk) disable iff (rst)
    proc && (in_kind == KIND_SAMPLE) |=> $stable(x_st) && $stable(y_st))
    else $error("sample beat altered axis state");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_cnt != 2'd3)
    else $error("output buffer overfilled");

  a_pair_first_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_cnt == 2'd2) |-> !m_tlast)
    else $error("first of two events marked last");

endmodule

// ----- rtl/jan_axis.sv -----
module jan_axis
  import jan_pkg::*;
(
  input  cfg_t                  cfg,
  input  axis_state_t           cur,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [TIME_W-1:0]     now_ms,
  output axis_state_t           nxt,
  output logic                  emit,
  output logic                  positive
);

  logic signed [SAMPLE_W:0] s_ext;
  logic signed [SAMPLE_W:0] t_pos;
  logic signed [SAMPLE_W:0] t_neg;
  logic        [SAMPLE_W:0] mag;
  logic        [TIME_W-1:0] elapsed;
  logic        [TIME_W-1:0] limit;

  assign s_ext   = {sample[SAMPLE_W-1], sample};
  assign t_pos   = $signed({2'b00, cfg.trigger_level});
  assign t_neg   = -t_pos;
  assign mag     = sample[SAMPLE_W-1] ? (SAMPLE_W+1)'(-s_ext) : (SAMPLE_W+1)'(s_ext);
  assign elapsed = now_ms - cur.mark;
  assign limit   = cur.repeating ? {{(TIME_W-MS_W){1'b0}}, cfg.repeat_interval_ms}
                                 : {{(TIME_W-MS_W){1'b0}}, cfg.repeat_delay_ms};

  always_comb begin
    nxt      = cur;
    emit     = 1'b0;
    positive = 1'b0;
    if (cur.latch == LATCH_IDLE) begin
      if (s_ext < t_neg) begin
        nxt.latch = LATCH_NEG;
        nxt.mark  = now_ms;
        emit      = 1'b1;
      end else if (s_ext > t_pos) begin
        nxt.latch = LATCH_POS;
        nxt.mark  = now_ms;
        emit      = 1'b1;
        positive  = 1'b1;
      end
    end else if (mag < {2'b00, cfg.relax_level}) begin
      nxt.latch     = LATCH_IDLE;
      nxt.repeating = 1'b0;
      nxt.mark      = '0;
    end else if (elapsed > limit) begin
      nxt.repeating = 1'b1;
      nxt.mark      = now_ms;
      emit          = (cur.latch == LATCH_NEG) || (cur.latch == LATCH_POS);
      positive      = (cur.latch == LATCH_POS);
    end
  end

endmodule
